// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks used by bitmap_page_frame_allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types, sizes and helper functions of the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

    // Map geometry
    localparam int MAP_WORDS      = 1024;
    localparam int RESERVED_WORDS = 8;
    localparam int RES_EFF        = (RESERVED_WORDS > MAP_WORDS) ? MAP_WORDS : RESERVED_WORDS;
    localparam int MAP_AW         = $clog2(MAP_WORDS);
    localparam int SUM_WORDS      = (MAP_WORDS + 31) / 32;
    localparam int SUM_AW         = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int WIDX_W         = SUM_AW + 5;

    // Command and status codes
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_INIT  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Transaction payloads
    typedef struct packed {
        t_command    command;
        logic [31:0] address;
    } t_cmd_in;

    typedef struct packed {
        logic [31:0] page_address;
        t_status     status;
    } t_result;

    // Priority encoder results
    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } t_find32;

    typedef struct packed {
        logic              found;
        logic [SUM_AW-1:0] idx;
    } t_find_grp;

    // Lowest clear bit of a 32-bit word
    function automatic t_find32 first_zero32(input logic [31:0] v);
        t_find32 r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!v[i]) begin
                r.found = 1'b1;
                r.idx   = 5'(i);
            end
        end
        return r;
    endfunction

    // Lowest group that still has a non-full word
    function automatic t_find_grp first_zero_top(input logic [SUM_WORDS-1:0] v);
        t_find_grp r;
        r = '0;
        for (int i = SUM_WORDS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r.found = 1'b1;
                r.idx   = SUM_AW'(i);
            end
        end
        return r;
    endfunction

    // Summary bits of a group that lie past the end of the map read as full
    function automatic logic [31:0] pad_mask(input logic [SUM_AW-1:0] g);
        logic [31:0]     m;
        logic [WIDX_W:0] wi;
        m = '0;
        for (int k = 0; k < 32; k++) begin
            wi   = {1'b0, g, 5'(k)};
            m[k] = (wi >= (WIDX_W + 1)'(MAP_WORDS));
        end
        return m;
    endfunction

    // Summary word of the reset map: one bit set for each reserved word
    function automatic logic [31:0] res_summary(input logic [MAP_AW-1:0] j);
        logic [31:0]       m;
        logic [MAP_AW+5:0] wi;
        m = '0;
        for (int k = 0; k < 32; k++) begin
            wi   = {1'b0, j, 5'(k)};
            m[k] = (wi < (MAP_AW + 6)'(RES_EFF));
        end
        return m;
    endfunction

    // Group-full flags of the reset map
    function automatic logic [SUM_WORDS-1:0] top_reset();
        logic [SUM_WORDS-1:0] t;
        int                   lim;
        t = '0;
        for (int g = 0; g < SUM_WORDS; g++) begin
            lim  = (g * 32 + 32 > MAP_WORDS) ? MAP_WORDS : g * 32 + 32;
            t[g] = (lim <= RES_EFF);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bpfa_ram.sv -----
// ----------------------------------------------------------------------------
// bpfa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Used-page bitmap of 4 KiB frames with allocate, free, mark and init.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with i_start high and o_busy low;
// its result appears on o_result for exactly one cycle with o_strobe high,
// and the receiver cannot stall it. No new transaction is taken before the
// last is done. Allocate steps through S_A1, S_A2 and S_A3, free or mark
// through S_F1 and S_F2; a full map or an out-of-range address ends in S_A1
// or S_F1. The states follow the read-modify-write chain over the two
// memories: a group-full flag register feeds a priority encoder, which picks
// a summary word (one full bit per map word) to read, whose encoder picks
// the map word to read, modify and write back. After reset the block is busy
// while a clearing pass writes the reset map; init runs the same pass.
`default_nettype none

`include "assert_macros.svh"

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_cmd_in i_cmd,
    output logic         o_busy,
    output logic         o_strobe,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_A1,
        S_A2,
        S_A3,
        S_F1,
        S_F2
    } t_state;

    t_state               r_state;
    t_command             r_cmd;
    logic [31:0]          r_addr;
    logic [SUM_AW-1:0]    r_grp;
    logic [4:0]           r_sub;
    logic [31:0]          r_sum;
    logic [MAP_AW-1:0]    r_cnt;
    logic [SUM_WORDS-1:0] r_top;
    logic                 r_init_res;
    logic                 r_strobe;
    t_result              r_result;

    // Memory ports
    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic [31:0]          map_wdata;
    logic [MAP_AW-1:0]    map_raddr;
    logic [31:0]          map_rdata;
    logic                 sum_we;
    logic [SUM_AW-1:0]    sum_waddr;
    logic [31:0]          sum_wdata;
    logic [SUM_AW-1:0]    sum_raddr;
    logic [31:0]          sum_rdata;

    // Datapath
    t_find_grp            find_top;
    t_find32              find_sum;
    t_find32              find_bit;
    logic [31:0]          sum_cur;
    logic [31:0]          sum_base;
    logic [31:0]          new_word;
    logic [31:0]          new_sum;
    logic [31:0]          kmask;
    logic [31:0]          bmask;
    logic [WIDX_W-1:0]    alloc_word;
    logic [WIDX_W-1:0]    rmw_word;
    logic [WIDX_W+4:0]    frame;
    logic                 in_range;
    logic                 clr_last;

    bpfa_ram #(.DEPTH(MAP_WORDS), .WIDTH(32)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    bpfa_ram #(.DEPTH(SUM_WORDS), .WIDTH(32)) u_sum (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // Find free frames and build modified words
    always_comb begin
        find_top   = first_zero_top(r_top);
        sum_cur    = sum_rdata | pad_mask(r_grp);
        find_sum   = first_zero32(sum_cur);
        find_bit   = first_zero32(map_rdata);
        alloc_word = {r_grp, find_sum.idx};
        rmw_word   = {r_grp, r_sub};
        frame      = {r_grp, r_sub, find_bit.idx};
        kmask      = 32'd1 << r_sub;
        in_range   = ({1'b0, r_addr[31:17]} < 16'(MAP_WORDS));
        clr_last   = (r_cnt == MAP_AW'(MAP_WORDS - 1));

        if (r_state == S_A3) begin
            bmask = 32'd1 << find_bit.idx;
        end else begin
            bmask = 32'd1 << r_addr[16:12];
        end

        if (r_state == S_F2 && r_cmd == CMD_FREE) begin
            new_word = map_rdata & ~bmask;
        end else begin
            new_word = map_rdata | bmask;
        end

        sum_base = (r_state == S_A3) ? r_sum : sum_cur;
        if (&new_word) begin
            new_sum = sum_base | kmask;
        end else begin
            new_sum = sum_base & ~kmask;
        end
    end

    // Drive memory ports
    always_comb begin
        map_we    = 1'b0;
        map_waddr = rmw_word[MAP_AW-1:0];
        map_wdata = new_word;
        map_raddr = r_addr[17+MAP_AW-1:17];
        sum_we    = 1'b0;
        sum_waddr = r_grp;
        sum_wdata = new_sum;
        sum_raddr = r_addr[22+SUM_AW-1:22];

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_cnt;
                map_wdata = ({1'b0, r_cnt} < (MAP_AW + 1)'(RES_EFF)) ? 32'hFFFF_FFFF : 32'd0;
                sum_we    = ({1'b0, r_cnt} < (MAP_AW + 1)'(SUM_WORDS));
                sum_waddr = r_cnt[SUM_AW-1:0];
                sum_wdata = res_summary(r_cnt);
            end
            S_A1: begin
                sum_raddr = find_top.idx;
            end
            S_A2: begin
                map_raddr = alloc_word[MAP_AW-1:0];
            end
            S_A3, S_F2: begin
                map_we = 1'b1;
                sum_we = 1'b1;
            end
            S_IDLE, S_F1: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_top      <= top_reset();
            r_init_res <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd  <= i_cmd.command;
                        r_addr <= i_cmd.address;
                        unique case (i_cmd.command)
                            CMD_ALLOC: r_state <= S_A1;
                            CMD_FREE, CMD_MARK: r_state <= S_F1;
                            CMD_INIT: begin
                                r_cnt      <= '0;
                                r_top      <= top_reset();
                                r_init_res <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (clr_last) begin
                        r_state <= S_IDLE;
                        if (r_init_res) begin
                            r_init_res            <= 1'b0;
                            r_strobe              <= 1'b1;
                            r_result.page_address <= 32'd0;
                            r_result.status       <= ST_OK;
                        end
                    end
                end
                S_A1: begin
                    if (find_top.found) begin
                        r_grp   <= find_top.idx;
                        r_state <= S_A2;
                    end else begin
                        r_strobe              <= 1'b1;
                        r_result.page_address <= 32'd0;
                        r_result.status       <= ST_FULL;
                        r_state               <= S_IDLE;
                    end
                end
                S_A2: begin
                    r_sum   <= sum_cur;
                    r_sub   <= find_sum.idx;
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_top[r_grp]          <= &(new_sum | pad_mask(r_grp));
                    r_strobe              <= 1'b1;
                    r_result.page_address <= 32'(frame) << 12;
                    r_result.status       <= ST_OK;
                    r_state               <= S_IDLE;
                end
                S_F1: begin
                    if (in_range) begin
                        r_grp   <= r_addr[22+SUM_AW-1:22];
                        r_sub   <= r_addr[21:17];
                        r_state <= S_F2;
                    end else begin
                        r_strobe              <= 1'b1;
                        r_result.page_address <= 32'd0;
                        r_result.status       <= ST_RANGE;
                        r_state               <= S_IDLE;
                    end
                end
                S_F2: begin
                    r_top[r_grp]          <= &new_sum;
                    r_strobe              <= 1'b1;
                    r_result.page_address <= {r_addr[31:12], 12'd0};
                    r_result.status       <= ST_OK;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Each result is a single-cycle pulse
    `ASSERT_NXT(a_strobe_pulse, o_strobe, !o_strobe, "result strobe lasted two cycles")
    // A full map never reports a frame address
    `ASSERT_IMP(a_full_zero, o_strobe && o_result.status == ST_FULL,
        o_result.page_address == 32'd0, "full status with nonzero address")
    // An accepted transaction makes the block busy
    `ASSERT_NXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted command left block idle")
    // The map is only written by a transaction in progress or the clearing pass
    `ASSERT_IMP(a_idle_no_write, r_state == S_IDLE, !map_we && !sum_we, "memory write while idle")

endmodule

`default_nettype wire
